### design/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg: shared types for the pixel extremum statistics core
// Pixel request and report payloads, the per-frame summary record that
// passes from the tracking front end to the report back end, and the
// report kind codes.
// ----------------------------------------------------------------------------
package pes_pkg;

	// Register map: one register, at byte address 0.
	localparam int unsigned       ADDR_W       = 3;
	localparam logic              REG_SEL_WIDTH = 1'b0;
	localparam int unsigned       CFG_W        = 13;
	localparam logic [CFG_W-1:0]  WIDTH_RESET  = 13'd640;

	// Kinds of report, in the order they leave the block.
	typedef enum logic [2:0] {
		KIND_MAX_SUM   = 3'd0,
		KIND_MIN_SUM   = 3'd1,
		KIND_MAX_RED   = 3'd2,
		KIND_MAX_GREEN = 3'd3,
		KIND_MAX_BLUE  = 3'd4,
		KIND_MIN_RED   = 3'd5,
		KIND_MIN_GREEN = 3'd6,
		KIND_MIN_BLUE  = 3'd7
	} result_kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pixel_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  pix_red;
		logic [7:0]  pix_green;
		logic [7:0]  pix_blue;
		logic [9:0]  level;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [11:0] y;
		logic [11:0] x;
	} place_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	// Extremes of one finished frame. Channel index 0 is red, 2 is blue.
	typedef struct packed {
		logic [9:0]            top_sum;
		place_t                top_place;
		color_t                top_color;
		logic [9:0]            low_sum;
		place_t                low_place;
		color_t                low_color;
		logic [2:0][7:0]       chan_top;
		logic [2:0][23:0]      chan_top_place;
		logic [2:0][7:0]       chan_low;
		logic [2:0][23:0]      chan_low_place;
	} frame_summary_t;

	// Status of the summary queue as seen by the front end and the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

### design/pixel_extremum_statistics_core.sv
// ----------------------------------------------------------------------------
// pixel_extremum_statistics_core: per-frame extremum statistics of RGB pixels
// Top level: configuration port, tracking front end, summary queue and
// report back end.
// ----------------------------------------------------------------------------
// The core takes one pixel request per clock and keeps its own raster
// position, wrapping the column at image_width (register 0, byte address 0,
// reset 640; zero acts as one). Each pixel updates the max/min sum and
// max/min per-channel trackers in the same cycle it is taken. The frame-end
// pixel closes the frame: its summary goes into a two-entry queue and the
// back end then delivers eight reports from it, one per clock when the
// receiver does not stall, so the reporting of one frame overlaps the
// tracking of the next. Pixels are stalled only when a frame-end pixel
// arrives while both queue entries still hold unreported frames, which can
// happen only for frames shorter than eight pixels or under output stalls.
// Each report is registered from the frame summary at the queue head.
// ----------------------------------------------------------------------------
module pixel_extremum_statistics_core #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pes_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  pes_pkg::pixel_t             pixel,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	output pes_pkg::result_t            result,
	output logic                        result_valid,
	input  logic                        result_stall
);
	import pes_pkg::*;

	logic [CFG_W-1:0] image_width_q;
	logic             cfg_write;
	logic             push;
	logic             pop;
	frame_summary_t   summary;
	frame_summary_t   head;
	queue_status_t    q_status;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[2] == REG_SEL_WIDTH) ? {19'd0, image_width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_write && paddr[2] == REG_SEL_WIDTH) begin
			image_width_q <= pwdata[CFG_W-1:0];
		end
	end

	pes_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.q_status    (q_status),
		.push        (push),
		.summary     (summary)
	);

	pes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (summary),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	pes_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// A closed frame is always waiting in the queue on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall && pixel.frame_end) |=> !q_status.empty)
		else $error("frame summary lost after frame-end pixel");

	// The last-report flag marks exactly the minimum-blue report.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.run_last == (result.result_kind == KIND_MIN_BLUE)))
		else $error("run_last out of step with report kind");

	// A register write lands in the width register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && paddr[2] == REG_SEL_WIDTH) |=>
		(image_width_q == $past(pwdata[CFG_W-1:0])))
		else $error("image width write not taken");

endmodule

### design/pes_front.sv
// ----------------------------------------------------------------------------
// pes_front: raster counters and extremum trackers
// Accepts one pixel per cycle unless a frame-end pixel finds the queue full,
// tracks column and row, updates the trackers, and pushes each frame summary.
// ----------------------------------------------------------------------------
module pes_front #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [pes_pkg::CFG_W-1:0] image_width,
	input  pes_pkg::pixel_t          pixel,
	input  logic                     pixel_valid,
	output logic                     pixel_stall,
	input  pes_pkg::queue_status_t   q_status,
	output logic                     push,
	output pes_pkg::frame_summary_t  summary
);
	import pes_pkg::*;

	localparam int unsigned WCAP_INT = (MAX_WIDTH > 4096) ? 4096 : MAX_WIDTH;
	localparam int unsigned HCAP_INT = (MAX_HEIGHT > 4096) ? 4096 :
	                                   ((MAX_HEIGHT == 0) ? 1 : MAX_HEIGHT);
	localparam logic [CFG_W-1:0] WIDTH_CAP = CFG_W'(WCAP_INT);
	localparam logic [11:0]      ROW_LAST  = 12'(HCAP_INT - 1);

	logic        accept;
	logic        fresh_q;
	logic [11:0] col_q;
	logic [11:0] row_q;

	logic [9:0]      top_sum_q, low_sum_q;
	place_t          top_place_q, low_place_q;
	color_t          top_color_q, low_color_q;
	logic [2:0][7:0]  chan_top_q, chan_low_q;
	logic [2:0][23:0] chan_top_place_q, chan_low_place_q;

	logic [9:0]       sum;
	logic [2:0][7:0]  chan;
	place_t           place;
	color_t           color;
	logic [CFG_W-1:0] width_eff;
	logic [CFG_W-1:0] col_inc;
	frame_summary_t   nxt;

	// A frame-end pixel needs a free summary slot; other pixels never wait.
	assign pixel_stall = q_status.full & pixel.frame_end;
	assign accept      = pixel_valid & ~pixel_stall;
	assign push        = accept & pixel.frame_end;
	assign summary     = nxt;

	// Pixel decode.
	assign chan[0] = pixel.red;
	assign chan[1] = pixel.green;
	assign chan[2] = pixel.blue;
	assign sum     = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
	assign color   = '{r: pixel.red, g: pixel.green, b: pixel.blue};
	assign place   = '{y: row_q, x: col_q};

	// Tracker update. Strict compares keep the first occurrence.
	always_comb begin
		nxt.top_sum        = top_sum_q;
		nxt.top_place      = top_place_q;
		nxt.top_color      = top_color_q;
		nxt.low_sum        = low_sum_q;
		nxt.low_place      = low_place_q;
		nxt.low_color      = low_color_q;
		nxt.chan_top       = chan_top_q;
		nxt.chan_top_place = chan_top_place_q;
		nxt.chan_low       = chan_low_q;
		nxt.chan_low_place = chan_low_place_q;
		if (fresh_q || sum > top_sum_q) begin
			nxt.top_sum   = sum;
			nxt.top_place = place;
			nxt.top_color = color;
		end
		if (fresh_q || sum < low_sum_q) begin
			nxt.low_sum   = sum;
			nxt.low_place = place;
			nxt.low_color = color;
		end
		for (int c = 0; c < 3; c++) begin
			if (fresh_q || chan[c] > chan_top_q[c]) begin
				nxt.chan_top[c]       = chan[c];
				nxt.chan_top_place[c] = place;
			end
			if (fresh_q || chan[c] < chan_low_q[c]) begin
				nxt.chan_low[c]       = chan[c];
				nxt.chan_low_place[c] = place;
			end
		end
	end

	// Effective row width: zero counts as one, large values are capped.
	always_comb begin
		if (image_width == '0) begin
			width_eff = CFG_W'(1);
		end else if (image_width > WIDTH_CAP) begin
			width_eff = WIDTH_CAP;
		end else begin
			width_eff = image_width;
		end
	end

	assign col_inc = {1'b0, col_q} + CFG_W'(1);

	// Raster position and frame start flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				fresh_q <= 1'b1;
				col_q   <= '0;
				row_q   <= '0;
			end else begin
				fresh_q <= 1'b0;
				if (col_inc >= width_eff) begin
					col_q <= '0;
					if (row_q < ROW_LAST) begin
						row_q <= row_q + 12'd1;
					end
				end else begin
					col_q <= col_inc[11:0];
				end
			end
		end
	end

	// Tracker registers; the frame start flag makes their old values moot.
	always_ff @(posedge clk) begin
		if (accept) begin
			top_sum_q        <= nxt.top_sum;
			top_place_q      <= nxt.top_place;
			top_color_q      <= nxt.top_color;
			low_sum_q        <= nxt.low_sum;
			low_place_q      <= nxt.low_place;
			low_color_q      <= nxt.low_color;
			chan_top_q       <= nxt.chan_top;
			chan_top_place_q <= nxt.chan_top_place;
			chan_low_q       <= nxt.chan_low;
			chan_low_place_q <= nxt.chan_low_place;
		end
	end

endmodule

### design/pes_queue.sv
// ----------------------------------------------------------------------------
// pes_queue: two-entry queue of frame summaries
// Decouples the tracking front end from the report back end so that the
// next frame can be tracked while the previous one is still reported.
// ----------------------------------------------------------------------------
module pes_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pes_pkg::frame_summary_t push_data,
	input  logic                    pop,
	output pes_pkg::frame_summary_t head,
	output pes_pkg::queue_status_t  status
);
	import pes_pkg::*;

	frame_summary_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign head         = slot_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### design/pes_back.sv
// ----------------------------------------------------------------------------
// pes_back: report sequencer
// Walks the head frame summary through its eight reports into a registered
// output, one per cycle unless stalled, and releases it after the last one.
// ----------------------------------------------------------------------------
module pes_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pes_pkg::frame_summary_t head,
	input  pes_pkg::queue_status_t  q_status,
	output logic                    pop,
	output pes_pkg::result_t        result,
	output logic                    result_valid,
	input  logic                    result_stall
);
	import pes_pkg::*;

	result_kind_t kind_q;
	logic         valid_q;
	result_t      out_q;
	result_t      rpt;
	logic         load;

	// Load while a summary is queued and the output register is free or taken.
	assign load         = ~q_status.empty & (~valid_q | ~result_stall);
	assign pop          = load & (kind_q == KIND_MIN_BLUE);
	assign result       = out_q;
	assign result_valid = valid_q;

	// Report selection for the current kind.
	always_comb begin
		rpt             = '0;
		rpt.result_kind = kind_q;
		rpt.run_last    = (kind_q == KIND_MIN_BLUE);
		unique case (kind_q)
			KIND_MAX_SUM: begin
				rpt.pos_x     = head.top_place.x;
				rpt.pos_y     = head.top_place.y;
				rpt.pix_red   = head.top_color.r;
				rpt.pix_green = head.top_color.g;
				rpt.pix_blue  = head.top_color.b;
				rpt.level     = head.top_sum;
			end
			KIND_MIN_SUM: begin
				rpt.pos_x     = head.low_place.x;
				rpt.pos_y     = head.low_place.y;
				rpt.pix_red   = head.low_color.r;
				rpt.pix_green = head.low_color.g;
				rpt.pix_blue  = head.low_color.b;
				rpt.level     = head.low_sum;
			end
			KIND_MAX_RED: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_top_place[0];
				rpt.level              = {2'b00, head.chan_top[0]};
			end
			KIND_MAX_GREEN: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_top_place[1];
				rpt.level              = {2'b00, head.chan_top[1]};
			end
			KIND_MAX_BLUE: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_top_place[2];
				rpt.level              = {2'b00, head.chan_top[2]};
			end
			KIND_MIN_RED: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_low_place[0];
				rpt.level              = {2'b00, head.chan_low[0]};
			end
			KIND_MIN_GREEN: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_low_place[1];
				rpt.level              = {2'b00, head.chan_low[1]};
			end
			KIND_MIN_BLUE: begin
				{rpt.pos_y, rpt.pos_x} = head.chan_low_place[2];
				rpt.level              = {2'b00, head.chan_low[2]};
			end
		endcase
	end

	// Kind counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_MAX_SUM;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				kind_q  <= result_kind_t'(kind_q + 3'd1);
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= rpt;
		end
	end

endmodule

### tb/pixel_extremum_statistics_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_extremum_statistics_core_tb: self-checking bench for the extremum core
// Streams RGB pixel requests through the core under several idle and stall
// mixes and image widths. A behavioral tracker predicts the eight reports of
// each frame, and every report taken from the core is checked field by field.
// ----------------------------------------------------------------------------
module pixel_extremum_statistics_core_tb;
	import pes_pkg::*;

	localparam int unsigned COL_LIMIT  = 4096;
	localparam int unsigned ROW_LIMIT  = 4096;
	localparam int          HALF_CYCLE = 6;
	localparam int          SETTLE     = 8;
	localparam int          HOLD_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 400000;

	localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

	// Clock, reset and the signals driven into the core.
	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr  = '0;
	logic [31:0] pwdata       = '0;
	pixel_t      pixel        = '0;
	logic        pixel_valid  = 1'b0;
	logic        result_stall = 1'b0;

	logic [31:0] prdata;
	logic        pready;
	logic        pixel_stall;
	result_t     result;
	logic        result_valid;

	// Stimulus and bookkeeping.
	pixel_t      pending_pixels [$];
	result_t     expected_reports [$];
	bit          pix_accepted = 1'b0;
	int          idle_pct     = 0;
	int          stall_pct    = 0;
	bit          hold_go      = 1'b0;
	int          hold_left    = 0;
	int          errors       = 0;
	int          cycle_cnt    = 0;

	// Predictor state: raster position, configuration and frame extremes.
	logic [12:0] width_reg = WIDTH_RESET;
	int unsigned col_pos   = 0;
	int unsigned row_pos   = 0;
	bit          frame_open = 1'b0;
	logic [9:0]  top_sum, low_sum;
	place_t      top_sum_at, low_sum_at;
	color_t      top_rgb, low_rgb;
	logic [7:0]  chan_hi [3];
	logic [7:0]  chan_lo [3];
	place_t      chan_hi_at [3];
	place_t      chan_lo_at [3];
	result_kind_t hi_kinds [3] = '{KIND_MAX_RED, KIND_MAX_GREEN, KIND_MAX_BLUE};
	result_kind_t lo_kinds [3] = '{KIND_MIN_RED, KIND_MIN_GREEN, KIND_MIN_BLUE};

	pixel_extremum_statistics_core #(
		.MAX_WIDTH (COL_LIMIT),
		.MAX_HEIGHT(ROW_LIMIT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always begin
		clk = 1'b0;
		#HALF_CYCLE;
		clk = 1'b1;
		#HALF_CYCLE;
	end

	// Update the frame extremes with one accepted pixel and, on the frame end,
	// queue the eight reports in the order the core sends them.
	task automatic track_pixel(input pixel_t p);
		logic [7:0]  ch [3];
		logic [9:0]  s;
		place_t      here;
		color_t      rgb;
		int unsigned span;
		result_t     r;
		ch = '{p.red, p.green, p.blue};
		s = 10'(p.red) + 10'(p.green) + 10'(p.blue);
		here.x = col_pos[11:0];
		here.y = row_pos[11:0];
		rgb = {p.red, p.green, p.blue};

		if (!frame_open) begin
			top_sum = s; top_sum_at = here; top_rgb = rgb;
			low_sum = s; low_sum_at = here; low_rgb = rgb;
			for (int c = 0; c < 3; c++) begin
				chan_hi[c] = ch[c]; chan_hi_at[c] = here;
				chan_lo[c] = ch[c]; chan_lo_at[c] = here;
			end
			frame_open = 1'b1;
		end else begin
			// Strict comparisons keep the first occurrence in raster order.
			if (s > top_sum) begin
				top_sum = s; top_sum_at = here; top_rgb = rgb;
			end
			if (s < low_sum) begin
				low_sum = s; low_sum_at = here; low_rgb = rgb;
			end
			for (int c = 0; c < 3; c++) begin
				if (ch[c] > chan_hi[c]) begin
					chan_hi[c] = ch[c]; chan_hi_at[c] = here;
				end
				if (ch[c] < chan_lo[c]) begin
					chan_lo[c] = ch[c]; chan_lo_at[c] = here;
				end
			end
		end

		// Zero width acts as one, and the width is capped at the column limit.
		span = (width_reg == 0) ? 1 : ((width_reg > COL_LIMIT) ? COL_LIMIT : width_reg);
		if (col_pos + 1 >= span) begin
			col_pos = 0;
			if (row_pos + 1 < ROW_LIMIT)
				row_pos++;
		end else begin
			col_pos++;
		end

		if (p.frame_end) begin
			r = '0;
			r.result_kind = KIND_MAX_SUM;
			r.pos_x = top_sum_at.x; r.pos_y = top_sum_at.y;
			r.pix_red = top_rgb.r; r.pix_green = top_rgb.g; r.pix_blue = top_rgb.b;
			r.level = top_sum;
			expected_reports.push_back(r);
			r.result_kind = KIND_MIN_SUM;
			r.pos_x = low_sum_at.x; r.pos_y = low_sum_at.y;
			r.pix_red = low_rgb.r; r.pix_green = low_rgb.g; r.pix_blue = low_rgb.b;
			r.level = low_sum;
			expected_reports.push_back(r);
			for (int c = 0; c < 3; c++) begin
				r = '0;
				r.result_kind = hi_kinds[c];
				r.pos_x = chan_hi_at[c].x; r.pos_y = chan_hi_at[c].y;
				r.level = 10'(chan_hi[c]);
				expected_reports.push_back(r);
			end
			for (int c = 0; c < 3; c++) begin
				r = '0;
				r.result_kind = lo_kinds[c];
				r.pos_x = chan_lo_at[c].x; r.pos_y = chan_lo_at[c].y;
				r.level = 10'(chan_lo[c]);
				r.run_last = (lo_kinds[c] == KIND_MIN_BLUE);
				expected_reports.push_back(r);
			end
			col_pos = 0;
			row_pos = 0;
			frame_open = 1'b0;
		end
	endtask

	task automatic cmp_field(input string name, input logic [2:0] kind,
			input logic [11:0] want, input logic [11:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: report kind %0d, %s expected %0d, got %0d",
				$time, kind, name, want, got);
		end
	endtask

	task automatic check_report(input result_t got);
		result_t want;
		if (expected_reports.size() == 0) begin
			errors++;
			$display("%0t: unexpected report, expected none, got kind %0d", $time,
				got.result_kind);
		end else begin
			want = expected_reports.pop_front();
			cmp_field("result_kind", want.result_kind, 12'(want.result_kind),
				12'(got.result_kind));
			cmp_field("pos_x", want.result_kind, want.pos_x, got.pos_x);
			cmp_field("pos_y", want.result_kind, want.pos_y, got.pos_y);
			cmp_field("pix_red", want.result_kind, 12'(want.pix_red), 12'(got.pix_red));
			cmp_field("pix_green", want.result_kind, 12'(want.pix_green),
				12'(got.pix_green));
			cmp_field("pix_blue", want.result_kind, 12'(want.pix_blue), 12'(got.pix_blue));
			cmp_field("level", want.result_kind, 12'(want.level), 12'(got.level));
			cmp_field("run_last", want.result_kind, 12'(want.run_last), 12'(got.run_last));
		end
	endtask

	// Monitor: take pixel requests into the predictor and check reports.
	always @(posedge clk) begin
		pix_accepted = arst_n && pixel_valid && !pixel_stall;
		if (pix_accepted)
			track_pixel(pixel);
		if (arst_n && result_valid && !result_stall)
			check_report(result);
	end

	// Pixel driver: a new request goes out only once the current one is taken.
	always @(negedge clk) begin : pixel_driver
		pixel_t next_pix;
		logic   next_valid;
		next_pix = pixel;
		next_valid = pixel_valid;
		if (!pixel_valid || pix_accepted) begin
			next_valid = 1'b0;
			if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
				next_pix = pending_pixels.pop_front();
				next_valid = 1'b1;
			end
		end
		pixel <= next_pix;
		pixel_valid <= next_valid;
	end

	// Report receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("pixel_extremum_statistics_core: mismatch");
			$finish;
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Write the image width, with noise in the unused upper bits, and read it back.
	task automatic write_width(input logic [12:0] val);
		apb_write(ADDR_IMAGE_WIDTH, {19'($urandom), val});
		width_reg = val;
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_IMAGE_WIDTH;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== width_reg) begin
			errors++;
			$display("%0t: image_width read expected %0d, got %0d", $time, width_reg,
				prdata[CFG_W-1:0]);
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// Wait until every request is taken and every report has arrived.
	task automatic wait_idle();
		while (pending_pixels.size() > 0 || pixel_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit last);
		pixel_t p;
		p.red = r; p.green = g; p.blue = b; p.frame_end = last;
		pending_pixels.push_back(p);
	endtask

	// Channel values lean on the extremes and on ties.
	function automatic logic [7:0] pick_level();
		case ($urandom_range(9))
			0, 1: pick_level = 8'd0;
			2, 3: pick_level = 8'd255;
			4: pick_level = 8'($urandom_range(2, 1));
			default: pick_level = 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [12:0] pick_width();
		case ($urandom_range(9))
			0: pick_width = 13'd0;
			1: pick_width = 13'd1;
			2: pick_width = 13'd4096;
			3: pick_width = 13'd8191;
			4: pick_width = 13'($urandom_range(8190, 4097));
			default: pick_width = 13'($urandom_range(16, 2));
		endcase
	endfunction

	task automatic queue_frame(input int len, input bit closed);
		for (int i = 0; i < len; i++)
			push_pixel(pick_level(), pick_level(), pick_level(), closed && i == len - 1);
	endtask

	// Longer frame with mid-range content and two planted extremes.
	task automatic queue_long_frame(input int len, input int hi_at);
		for (int i = 0; i < len; i++) begin
			if (i == hi_at)
				push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
			else if (i == hi_at + 1)
				push_pixel(8'd0, 8'd0, 8'd0, i == len - 1);
			else
				push_pixel(8'($urandom_range(254, 1)), 8'($urandom_range(254, 1)),
					8'($urandom_range(254, 1)), i == len - 1);
		end
	endtask

	initial begin
		int n;
		int len;
		int idle_mix [4];
		int stall_mix [4];
		idle_mix = '{0, 54, 0, 30};
		stall_mix = '{0, 0, 54, 30};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-pixel frames at both extremes, with the reset width.
		write_width(WIDTH_RESET);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		wait_idle();

		// Ties, opposing channel extremes and a row wrap at width three.
		write_width(13'd3);
		push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
		push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
		push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		push_pixel(8'd5, 8'd5, 8'd5, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		wait_idle();

		// Zero width acts as one; a write beyond the register map is ignored.
		write_width(13'd0);
		apb_write(ADDR_UNMAPPED, 32'd2);
		push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
		push_pixel(8'd2, 8'd2, 8'd2, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		wait_idle();

		// Width shrinks in the middle of a frame.
		write_width(13'd5);
		push_pixel(8'd7, 8'd8, 8'd9, 1'b0);
		push_pixel(8'd9, 8'd8, 8'd7, 1'b0);
		push_pixel(8'd3, 8'd200, 8'd3, 1'b0);
		wait_idle();
		write_width(13'd2);
		push_pixel(8'd100, 8'd1, 8'd100, 1'b0);
		push_pixel(8'd250, 8'd250, 8'd250, 1'b0);
		push_pixel(8'd0, 8'd9, 8'd0, 1'b1);
		wait_idle();

		// Width above the cap keeps the row; width one steps the row on every pixel.
		write_width(13'd8191);
		queue_long_frame(24, 20);
		wait_idle();
		write_width(13'd1);
		queue_long_frame(20, 18);
		wait_idle();

		// Random frames under each idle and stall mix, two widths per mix.
		for (int m = 0; m < 4; m++) begin
			idle_pct = idle_mix[m];
			stall_pct = stall_mix[m];
			for (int seg = 0; seg < 2; seg++) begin
				write_width(pick_width());
				n = 0;
				while (n < 32) begin
					case ($urandom_range(19))
						0: len = $urandom_range(120, 41);
						1, 2, 3, 4, 5: len = $urandom_range(40, 13);
						default: len = $urandom_range(12, 1);
					endcase
					queue_frame(len, 1'b1);
					n += len;
				end
				// Sometimes leave a frame open across the width change.
				if ($urandom_range(1))
					queue_frame($urandom_range(5, 1), 1'b0);
				wait_idle();
			end
		end

		// Long receiver hold-off with tiny frames so the summary queue fills.
		idle_pct = 0;
		stall_pct = 0;
		write_width(13'd3);
		hold_go = 1'b1;
		for (int f = 0; f < 40; f++)
			queue_frame($urandom_range(2, 1), 1'b1);
		wait_idle();

		if (errors == 0) begin
			$display("pixel_extremum_statistics_core: match");
		end else begin
			$display("pixel_extremum_statistics_core: mismatch");
		end
		$finish;
	end

endmodule

### sim.f
design/pes_pkg.sv
design/pes_front.sv
design/pes_queue.sv
design/pes_back.sv
design/pixel_extremum_statistics_core.sv
tb/pixel_extremum_statistics_core_tb.sv
